[rtl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and default configuration shared by the unit and its checker.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FUNC_W         = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_EQ  = 3'd4,
        FUNC_NE  = 3'd5
    } func_t;

endpackage

[rtl/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide and compare of complex signed fixed-point
// operands, with rounding, saturation and a divide-by-zero flag.
// ----------------------------------------------------------------------------
// The unit takes one operation per cycle while in_stall is low. Each result
// passes stages 1 to 4, the divider and the output register. The divider
// resolves one quotient bit per stage over DATA_WIDTH + 1 stages after its
// range check stage; every operation flows through the same stages so
// results leave in order. A two-entry output buffer lets the pipeline keep
// moving while a result waits, and in_stall rises only when both entries are
// full.
module complex_arith_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cau_pkg::FUNC_W-1:0]         func,
    input  logic signed [DATA_WIDTH-1:0]       a_re,
    input  logic signed [DATA_WIDTH-1:0]       a_im,
    input  logic signed [DATA_WIDTH-1:0]       b_re,
    input  logic signed [DATA_WIDTH-1:0]       b_im,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [DATA_WIDTH-1:0]       r_re,
    output logic signed [DATA_WIDTH-1:0]       r_im,
    output logic                               cmp_true,
    output logic                               div_by_zero,
    output logic                               saturated
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int RW = 2 * W + 2;
    localparam int QB = W + 1;
    localparam int NW = 2 * W + F + 2;
    localparam int DW = 2 * W + 1;
    localparam int CW = 3 * W + 2;

    localparam logic signed [RW-1:0] HALF = RW'(1) <<< (F - 1);
    localparam logic signed [RW-1:0] VMAX = {{(RW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [RW-1:0] VMIN = {{(RW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    typedef struct packed {
        func_t            func;
        logic             eq;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic [RW-1:0]    dv_re;
        logic [RW-1:0]    dv_im;
        logic [DW-1:0]    d;
    } ctl_t;

    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Stage 1: operand capture.
    logic                  s1_valid_reg;
    func_t                 s1_func_reg;
    logic                  s1_eq_reg;
    logic signed [W-1:0]   s1_are_reg, s1_aim_reg, s1_bre_reg, s1_bim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= func_t'(func);
            s1_eq_reg   <= (a_re == b_re) && (a_im == b_im);
            s1_are_reg  <= a_re;
            s1_aim_reg  <= a_im;
            s1_bre_reg  <= b_re;
            s1_bim_reg  <= b_im;
        end
    end

    // Stage 2: products and plain sums.
    logic                  s2_valid_reg;
    func_t                 s2_func_reg;
    logic                  s2_eq_reg;
    logic signed [PW-1:0]  s2_prr_reg, s2_pii_reg, s2_pri_reg, s2_pir_reg;
    logic signed [PW-1:0]  s2_pbr_reg, s2_pbi_reg;
    logic signed [W:0]     s2_sre_reg, s2_sim_reg;
    logic signed [W:0]     sre_next, sim_next;
    logic signed [W:0]     are_x, aim_x, bre_x, bim_x;

    assign are_x = {s1_are_reg[W-1], s1_are_reg};
    assign aim_x = {s1_aim_reg[W-1], s1_aim_reg};
    assign bre_x = {s1_bre_reg[W-1], s1_bre_reg};
    assign bim_x = {s1_bim_reg[W-1], s1_bim_reg};

    always_comb
    begin
        if (s1_func_reg == FUNC_SUB)
        begin
            sre_next = are_x - bre_x;
            sim_next = aim_x - bim_x;
        end
        else
        begin
            sre_next = are_x + bre_x;
            sim_next = aim_x + bim_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_func_reg <= s1_func_reg;
            s2_eq_reg   <= s1_eq_reg;
            s2_prr_reg  <= PW'(s1_are_reg) * PW'(s1_bre_reg);
            s2_pii_reg  <= PW'(s1_aim_reg) * PW'(s1_bim_reg);
            s2_pri_reg  <= PW'(s1_are_reg) * PW'(s1_bim_reg);
            s2_pir_reg  <= PW'(s1_aim_reg) * PW'(s1_bre_reg);
            s2_pbr_reg  <= PW'(s1_bre_reg) * PW'(s1_bre_reg);
            s2_pbi_reg  <= PW'(s1_bim_reg) * PW'(s1_bim_reg);
            s2_sre_reg  <= sre_next;
            s2_sim_reg  <= sim_next;
        end
    end

    // Stage 3: product sums, rounded products and squared divisor magnitude.
    logic                  s3_valid_reg;
    func_t                 s3_func_reg;
    logic                  s3_eq_reg;
    logic                  s3_dz_reg;
    logic signed [RW-1:0]  s3_dvre_reg, s3_dvim_reg;
    logic signed [SW-1:0]  s3_nre_reg, s3_nim_reg;
    logic [PW-1:0]         s3_den_reg;
    logic signed [RW-1:0]  mre_w, mim_w, dvre_next, dvim_next;
    logic [PW-1:0]         den_next;

    assign mre_w    = RW'(s2_prr_reg) - RW'(s2_pii_reg) + HALF;
    assign mim_w    = RW'(s2_pri_reg) + RW'(s2_pir_reg) + HALF;
    assign den_next = $unsigned(s2_pbr_reg) + $unsigned(s2_pbi_reg);

    always_comb
    begin
        case (s2_func_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                dvre_next = RW'(s2_sre_reg);
                dvim_next = RW'(s2_sim_reg);
            end
            FUNC_MUL:
            begin
                dvre_next = mre_w >>> F;
                dvim_next = mim_w >>> F;
            end
            default:
            begin
                dvre_next = '0;
                dvim_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_func_reg <= s2_func_reg;
            s3_eq_reg   <= s2_eq_reg;
            s3_dz_reg   <= (s2_func_reg == FUNC_DIV) && (den_next == '0);
            s3_dvre_reg <= dvre_next;
            s3_dvim_reg <= dvim_next;
            s3_nre_reg  <= SW'(s2_prr_reg) + SW'(s2_pii_reg);
            s3_nim_reg  <= SW'(s2_pir_reg) - SW'(s2_pri_reg);
            s3_den_reg  <= den_next;
        end
    end

    // Stage 4: dividend magnitudes with the rounding term folded in.
    logic                  s4_valid_reg;
    ctl_t                  s4_ctl_reg;
    logic [NW-1:0]         s4_nre_reg, s4_nim_reg;
    logic [SW-1:0]         mag_re, mag_im;

    assign mag_re = s3_nre_reg[SW-1] ? $unsigned(-s3_nre_reg) : $unsigned(s3_nre_reg);
    assign mag_im = s3_nim_reg[SW-1] ? $unsigned(-s3_nim_reg) : $unsigned(s3_nim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctl_reg.func   <= s3_func_reg;
            s4_ctl_reg.eq     <= s3_eq_reg;
            s4_ctl_reg.dz     <= s3_dz_reg;
            s4_ctl_reg.neg_re <= s3_nre_reg[SW-1];
            s4_ctl_reg.neg_im <= s3_nim_reg[SW-1];
            s4_ctl_reg.dv_re  <= s3_dvre_reg;
            s4_ctl_reg.dv_im  <= s3_dvim_reg;
            s4_ctl_reg.d      <= {s3_den_reg, 1'b0};
            s4_nre_reg <= NW'({mag_re[PW-1:0], {(F + 1){1'b0}}}) + NW'(s3_den_reg);
            s4_nim_reg <= NW'({mag_im[PW-1:0], {(F + 1){1'b0}}}) + NW'(s3_den_reg);
        end
    end

    // Divider: range check stage, then one quotient bit per stage.
    logic                  dv_valid_reg [0:QB];
    ctl_t                  dv_ctl_reg   [0:QB];
    logic [NW-1:0]         rem_re_reg   [0:QB];
    logic [NW-1:0]         rem_im_reg   [0:QB];
    logic [QB-1:0]         q_re_reg     [0:QB];
    logic [QB-1:0]         q_im_reg     [0:QB];
    logic                  ovf_re_reg   [0:QB];
    logic                  ovf_im_reg   [0:QB];
    logic [CW-1:0]         dlim;

    assign dlim = CW'(s4_ctl_reg.d) << QB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ctl_reg[0] <= s4_ctl_reg;
            rem_re_reg[0] <= s4_nre_reg;
            rem_im_reg[0] <= s4_nim_reg;
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;
            ovf_re_reg[0] <= CW'(s4_nre_reg) >= dlim;
            ovf_im_reg[0] <= CW'(s4_nim_reg) >= dlim;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int B = QB - j;
        logic [CW-1:0] trial;
        logic          ge_re, ge_im;
        logic [NW-1:0] rre_next, rim_next;
        logic [QB-1:0] qre_next, qim_next;

        assign trial = CW'(dv_ctl_reg[j-1].d) << B;
        assign ge_re = CW'(rem_re_reg[j-1]) >= trial;
        assign ge_im = CW'(rem_im_reg[j-1]) >= trial;

        always_comb
        begin
            rre_next = rem_re_reg[j-1];
            rim_next = rem_im_reg[j-1];
            qre_next = q_re_reg[j-1];
            qim_next = q_im_reg[j-1];
            if (ge_re)
            begin
                rre_next    = NW'(CW'(rem_re_reg[j-1]) - trial);
                qre_next[B] = 1'b1;
            end
            if (ge_im)
            begin
                rim_next    = NW'(CW'(rem_im_reg[j-1]) - trial);
                qim_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_ctl_reg[j] <= dv_ctl_reg[j-1];
                rem_re_reg[j] <= rre_next;
                rem_im_reg[j] <= rim_next;
                q_re_reg[j]   <= qre_next;
                q_im_reg[j]   <= qim_next;
                ovf_re_reg[j] <= ovf_re_reg[j-1];
                ovf_im_reg[j] <= ovf_im_reg[j-1];
            end
        end
    end

    // Result selection and saturation.
    function automatic logic [W:0] sat_val(input logic signed [RW-1:0] v);
        logic [W:0] r;
        if (v > VMAX)
        begin
            r = {1'b1, VMAX[W-1:0]};
        end
        else if (v < VMIN)
        begin
            r = {1'b1, VMIN[W-1:0]};
        end
        else
        begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [W:0] div_val(input logic [QB-1:0] q, input logic neg,
                                           input logic ovf);
        logic signed [RW-1:0] qs;
        logic [W:0]           r;
        qs = $signed({{(RW - QB){1'b0}}, q});
        if (ovf)
        begin
            r = neg ? {1'b1, VMIN[W-1:0]} : {1'b1, VMAX[W-1:0]};
        end
        else
        begin
            r = sat_val(neg ? -qs : qs);
        end
        return r;
    endfunction

    ctl_t          fin_ctl;
    logic [W:0]    fin_re, fin_im;
    logic [W-1:0]  res_re, res_im;
    logic          res_cmp, res_dz, res_sat;

    assign fin_ctl = dv_ctl_reg[QB];

    always_comb
    begin
        res_dz  = fin_ctl.dz;
        res_cmp = ((fin_ctl.func == FUNC_EQ) && fin_ctl.eq) ||
                  ((fin_ctl.func == FUNC_NE) && !fin_ctl.eq);
        if (fin_ctl.func == FUNC_DIV)
        begin
            fin_re = div_val(q_re_reg[QB], fin_ctl.neg_re, ovf_re_reg[QB]);
            fin_im = div_val(q_im_reg[QB], fin_ctl.neg_im, ovf_im_reg[QB]);
        end
        else
        begin
            fin_re = sat_val($signed(fin_ctl.dv_re));
            fin_im = sat_val($signed(fin_ctl.dv_im));
        end
        if (fin_ctl.dz)
        begin
            res_re  = '0;
            res_im  = '0;
            res_sat = 1'b0;
        end
        else
        begin
            res_re  = fin_re[W-1:0];
            res_im  = fin_im[W-1:0];
            res_sat = fin_re[W] || fin_im[W];
        end
    end

    // Output register with one skid entry behind it.
    logic          out_valid_reg;
    logic [W-1:0]  out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    logic          out_cmp_reg, out_dz_reg, out_sat_reg;
    logic          skid_cmp_reg, skid_dz_reg, skid_sat_reg;
    logic          incoming, take;

    assign incoming = en && dv_valid_reg[QB];
    assign take     = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_re_reg  <= skid_re_reg;
                out_im_reg  <= skid_im_reg;
                out_cmp_reg <= skid_cmp_reg;
                out_dz_reg  <= skid_dz_reg;
                out_sat_reg <= skid_sat_reg;
            end
        end
        else if (incoming)
        begin
            if (out_valid_reg && !take)
            begin
                skid_re_reg  <= res_re;
                skid_im_reg  <= res_im;
                skid_cmp_reg <= res_cmp;
                skid_dz_reg  <= res_dz;
                skid_sat_reg <= res_sat;
            end
            else
            begin
                out_re_reg  <= res_re;
                out_im_reg  <= res_im;
                out_cmp_reg <= res_cmp;
                out_dz_reg  <= res_dz;
                out_sat_reg <= res_sat;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign r_re        = $signed(out_re_reg);
    assign r_im        = $signed(out_im_reg);
    assign cmp_true    = out_cmp_reg;
    assign div_by_zero = out_dz_reg;
    assign saturated   = out_sat_reg;

endmodule

[rtl/cau_checker.sv]
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic signed [DATA_WIDTH-1:0] r_re,
    input logic signed [DATA_WIDTH-1:0] r_im,
    input logic                         cmp_true,
    input logic                         div_by_zero,
    input logic                         saturated
);

    // A stalled result holds its parts and saturation flag until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(r_re) && $stable(r_im)
            && $stable(saturated))
        else $error("stalled result changed");

    // A compare result carries no arithmetic parts or flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmp_true |-> r_re == '0 && r_im == '0 && !saturated && !div_by_zero)
        else $error("compare result with nonzero parts");

    // A zero divisor gives a clean zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> r_re == '0 && r_im == '0 && !saturated && !cmp_true)
        else $error("divide by zero result not clean");

    // Input is held off only after an output stall with a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

endmodule

bind complex_arith_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .r_re        (r_re),
    .r_im        (r_im),
    .cmp_true    (cmp_true),
    .div_by_zero (div_by_zero),
    .saturated   (saturated)
);
